// ----- rtl/nwmf_pkg.sv -----
// ----------------------------------------------------------------------------
// nwmf_pkg
// Shared constants and types of the no-data window mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package nwmf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_RADIUS_DEF = 7;

    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_KERNEL_RADIUS = 3'd2;
    localparam logic [2:0] REG_KERNEL_SHAPE  = 3'd3;
    localparam logic [2:0] REG_FILTER_MODE   = 3'd4;

    localparam logic [10:0] RST_FRAME_WIDTH   = 11'd1024;
    localparam logic [15:0] RST_FRAME_HEIGHT  = 16'd1024;
    localparam logic [2:0]  RST_KERNEL_RADIUS = 3'd2;
    localparam logic        RST_KERNEL_SHAPE  = 1'b1;
    localparam logic [1:0]  RST_FILTER_MODE   = 2'd0;

    localparam logic [1:0] MODE_SMOOTH  = 2'd0;
    localparam logic [1:0] MODE_SHARPEN = 2'd1;
    localparam logic [1:0] MODE_EDGE    = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int VALUE_W  = 16;
    localparam int RESULT_W = 18;

    typedef struct packed {
        logic valid;
        logic centre;
    } rd_tag_t;

endpackage

`default_nettype wire

// ----- rtl/nwmf_stream_if.sv -----
// ----------------------------------------------------------------------------
// nwmf_pixel_if / nwmf_result_if
// Valid/ready channels for pixel transactions and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface nwmf_pixel_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic signed [15:0]   pixel_value;
    logic                 pixel_missing;

    modport source (output valid, kind, pixel_value, pixel_missing, input ready);
    modport sink   (input valid, kind, pixel_value, pixel_missing, output ready);
endinterface

interface nwmf_result_if;
    logic                 valid;
    logic                 ready;
    logic signed [17:0]   result_value;
    logic                 result_missing;
    logic                 frame_last;

    modport source (output valid, result_value, result_missing, frame_last, input ready);
    modport sink   (input valid, result_value, result_missing, frame_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/nwmf_line_store.sv -----
// ----------------------------------------------------------------------------
// nwmf_line_store
// Ring of line buffers: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nwmf_line_store #(
    parameter int DEPTH = 15360,
    parameter int WIDTH = 17
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- rtl/nwmf_div_cell.sv -----
// ----------------------------------------------------------------------------
// nwmf_div_cell
// One restoring-division step: resolves one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module nwmf_div_cell #(
    parameter int DIV_W = 24,
    parameter int DVS_W = 9
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [DVS_W-1:0] divisor,
    input  wire logic             in_valid,
    input  wire logic [DVS_W-1:0] in_rem,
    input  wire logic [DIV_W-1:0] in_dvd,
    input  wire logic [DIV_W-1:0] in_quo,
    output      logic             out_valid,
    output      logic [DVS_W-1:0] out_rem,
    output      logic [DIV_W-1:0] out_dvd,
    output      logic [DIV_W-1:0] out_quo
);

    logic [DVS_W:0] trial;
    logic           fits;

    assign trial = {in_rem, in_dvd[DIV_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rem <= fits ? DVS_W'(trial - {1'b0, divisor}) : DVS_W'(trial);
        out_dvd <= {in_dvd[DIV_W-2:0], 1'b0};
        out_quo <= {in_quo[DIV_W-2:0], fits};
    end

endmodule

`default_nettype wire

// ----- rtl/nwmf_divider.sv -----
// ----------------------------------------------------------------------------
// nwmf_divider
// Chain of registered division cells; the quotient leaves the last cell with done.
// ----------------------------------------------------------------------------
`default_nettype none

module nwmf_divider #(
    parameter int DIV_W = 24,
    parameter int DVS_W = 9
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output      logic             done,
    output      logic [DIV_W-1:0] quotient
);

    logic [DIV_W:0]   vld;
    logic [DVS_W-1:0] rem [DIV_W+1];
    logic [DIV_W-1:0] dvd [DIV_W+1];
    logic [DIV_W-1:0] quo [DIV_W+1];

    assign vld[0] = start;
    assign rem[0] = '0;
    assign dvd[0] = dividend;
    assign quo[0] = '0;

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_cell
        nwmf_div_cell #(
            .DIV_W (DIV_W),
            .DVS_W (DVS_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (divisor),
            .in_valid  (vld[i]),
            .in_rem    (rem[i]),
            .in_dvd    (dvd[i]),
            .in_quo    (quo[i]),
            .out_valid (vld[i+1]),
            .out_rem   (rem[i+1]),
            .out_dvd   (dvd[i+1]),
            .out_quo   (quo[i+1])
        );
    end

    assign done     = vld[DIV_W];
    assign quotient = quo[DIV_W];

endmodule

`default_nettype wire

// ----- rtl/nodata_window_mean_filter.sv -----
// ----------------------------------------------------------------------------
// nodata_window_mean_filter
// Streaming window mean filter over raster frames with no-data pixels.
//
//   channel   dir   handshake       payload
//   pixel     in    valid/ready     kind, pixel_value, pixel_missing
//   result    out   valid/ready     result_value, result_missing, frame_last
//   apb       in    psel/penable    paddr, pwdata, prdata (pready tied high)
//
// A transaction that yields no result is accepted without leaving S_IDLE. One that
// yields a result reads the centre, then does one line-store read per square
// window tap, then runs the division cell chain (DIV_W is 26 at the default
// sizes). A no-data centre skips the division. The line store is not cleared
// at reset. A stalled result is held in the output register while the next
// pixel is taken; the following result waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module nodata_window_mean_filter #(
    parameter int MAX_WIDTH  = nwmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_RADIUS = nwmf_pkg::MAX_RADIUS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [nwmf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output      logic [31:0]                  prdata,
    output      logic                         pready,
    nwmf_pixel_if.sink                        pixel,
    nwmf_result_if.source                     result
);

    localparam int RING   = 2 * MAX_RADIUS + 1;
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = $clog2(RING);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int OFS_W  = RAD_W + 1;
    localparam int SQ_W   = 2 * OFS_W + 1;
    localparam int LIN_W  = 16 + $clog2(MAX_WIDTH + 1);
    localparam int NMAX   = RING * RING;
    localparam int CNT_W  = $clog2(NMAX + 1);
    localparam int SUM_W  = 17 + $clog2(NMAX);
    localparam int DIV_W  = SUM_W + 1;
    localparam int DVS_W  = CNT_W + 1;
    localparam int RES_W  = nwmf_pkg::RESULT_W;
    localparam int VAL_W  = nwmf_pkg::VALUE_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CTR  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_PREP = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [10:0] fw_reg;
    logic [15:0] fh_reg;
    logic [2:0]  kr_reg;
    logic        ks_reg;
    logic [1:0]  fm_reg;

    logic [COL_W-1:0]  in_col_reg;
    logic [15:0]       in_row_reg;
    logic [SLOT_W-1:0] in_slot_reg;
    logic [LIN_W-1:0]  in_lin_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [15:0]       out_row_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [LIN_W-1:0]  out_lin_reg;

    logic signed [OFS_W-1:0] dx_reg;
    logic signed [OFS_W-1:0] dy_reg;
    logic [SLOT_W-1:0]       scan_slot_reg;

    nwmf_pkg::rd_tag_t       tag_reg;
    nwmf_pkg::rd_tag_t       tag_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    cen_missing_reg;
    logic signed [VAL_W-1:0] cen_v_reg;

    logic [DIV_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic             neg_reg;
    logic             launch_reg;
    logic [DIV_W-1:0] q_reg;

    logic                    out_valid_reg;
    logic signed [RES_W-1:0] res_value_reg;
    logic                    res_missing_reg;
    logic                    res_last_reg;

    logic [COL_W:0]   w_eff;
    logic [COL_W-1:0] wlast;
    logic [15:0]      h_eff;
    logic [15:0]      hlast;
    logic [RAD_W-1:0] r_eff;
    logic [LIN_W-1:0] lag;

    logic cfg_wr;
    logic cfg_hit;
    logic accept;
    logic input_done;
    logic has_cur;
    logic emit;

    logic signed [OFS_W-1:0] r_pos;
    logic signed [OFS_W-1:0] r_neg;
    logic [SLOT_W:0]         start_slot_sum;
    logic [SLOT_W-1:0]       start_slot;

    logic signed [COL_W+1:0] ix;
    logic signed [17:0]      iy;
    logic signed [SQ_W-1:0]  dd;
    logic signed [SQ_W-1:0]  rr;
    logic                    tap_ok;
    logic                    scan_end;

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [VAL_W:0]    rd_data;

    logic [SUM_W-1:0]        abs_sum;
    logic                    div_done;
    logic [DIV_W-1:0]        div_q;
    logic signed [RES_W-1:0] mean;
    logic signed [RES_W-1:0] v_ext;
    logic signed [RES_W-1:0] res_calc;
    logic                    is_last;
    logic                    load;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (paddr[4:2] <= nwmf_pkg::REG_FILTER_MODE);

    always_comb
    begin
        unique case (paddr[4:2])
            nwmf_pkg::REG_FRAME_WIDTH:   prdata = 32'(fw_reg);
            nwmf_pkg::REG_FRAME_HEIGHT:  prdata = 32'(fh_reg);
            nwmf_pkg::REG_KERNEL_RADIUS: prdata = 32'(kr_reg);
            nwmf_pkg::REG_KERNEL_SHAPE:  prdata = 32'(ks_reg);
            nwmf_pkg::REG_FILTER_MODE:   prdata = 32'(fm_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= nwmf_pkg::RST_FRAME_WIDTH;
            fh_reg <= nwmf_pkg::RST_FRAME_HEIGHT;
            kr_reg <= nwmf_pkg::RST_KERNEL_RADIUS;
            ks_reg <= nwmf_pkg::RST_KERNEL_SHAPE;
            fm_reg <= nwmf_pkg::RST_FILTER_MODE;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                nwmf_pkg::REG_FRAME_WIDTH:   fw_reg <= pwdata[10:0];
                nwmf_pkg::REG_FRAME_HEIGHT:  fh_reg <= pwdata[15:0];
                nwmf_pkg::REG_KERNEL_RADIUS: kr_reg <= pwdata[2:0];
                nwmf_pkg::REG_KERNEL_SHAPE:  ks_reg <= pwdata[0];
                nwmf_pkg::REG_FILTER_MODE:   fm_reg <= pwdata[1:0];
                default:                     ;
            endcase
        end
    end

    // Effective frame geometry
    always_comb
    begin
        if (fw_reg == 11'd0)
        begin
            w_eff = (COL_W+1)'(1);
        end
        else if (32'(fw_reg) > MAX_WIDTH)
        begin
            w_eff = (COL_W+1)'(MAX_WIDTH);
        end
        else
        begin
            w_eff = (COL_W+1)'(fw_reg);
        end
    end

    assign wlast = COL_W'(w_eff - 1'b1);
    assign h_eff = (fh_reg == 16'd0) ? 16'd1 : fh_reg;
    assign hlast = h_eff - 16'd1;
    assign r_eff = (32'(kr_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(kr_reg);
    assign lag   = LIN_W'(r_eff) * LIN_W'(w_eff) + LIN_W'(r_eff);

    // Input transaction decode
    assign pixel.ready = (state_reg == S_IDLE);
    assign accept      = pixel.valid && pixel.ready;
    assign input_done  = in_row_reg >= h_eff;
    assign has_cur     = accept && !input_done && (pixel.kind == nwmf_pkg::KIND_PIXEL);
    assign emit        = accept && (input_done || ((pixel.kind == nwmf_pkg::KIND_PIXEL) &&
                         (({1'b0, out_lin_reg} + {1'b0, lag}) <= {1'b0, in_lin_reg})));

    // Window scan
    assign r_pos          = $signed({1'b0, r_eff});
    assign r_neg          = -r_pos;
    assign start_slot_sum = (SLOT_W+1)'(out_slot_reg) + (SLOT_W+1)'(RING) - (SLOT_W+1)'(r_eff);
    assign start_slot     = (start_slot_sum >= (SLOT_W+1)'(RING)) ?
                            SLOT_W'(start_slot_sum - (SLOT_W+1)'(RING)) : SLOT_W'(start_slot_sum);

    assign ix = $signed({2'b00, out_col_reg}) + (COL_W+2)'(dx_reg);
    assign iy = $signed({2'b00, out_row_reg}) + 18'(dy_reg);
    assign dd = SQ_W'(dx_reg) * SQ_W'(dx_reg) + SQ_W'(dy_reg) * SQ_W'(dy_reg);
    assign rr = SQ_W'(r_pos) * SQ_W'(r_pos);

    assign tap_ok = (ix >= 0) && (ix <= $signed({2'b00, wlast})) &&
                    (iy >= 0) && (iy <= $signed({2'b00, hlast})) &&
                    (!ks_reg || (dd <= rr));
    assign scan_end = (dx_reg == r_pos) && (dy_reg == r_pos);

    assign wr_addr = ADDR_W'(in_slot_reg * MAX_WIDTH + in_col_reg);

    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            rd_addr = ADDR_W'(scan_slot_reg * MAX_WIDTH + ix[COL_W-1:0]);
        end
        else
        begin
            rd_addr = ADDR_W'(out_slot_reg * MAX_WIDTH + out_col_reg);
        end
    end

    always_comb
    begin
        tag_next.valid  = 1'b0;
        tag_next.centre = 1'b0;
        if (state_reg == S_CTR)
        begin
            tag_next.valid  = 1'b1;
            tag_next.centre = 1'b1;
        end
        else if (state_reg == S_SCAN)
        begin
            tag_next.valid = tap_ok;
        end
    end

    nwmf_line_store #(
        .DEPTH (DEPTH),
        .WIDTH (VAL_W + 1)
    ) u_store (
        .clk     (clk),
        .wr_en   (has_cur),
        .wr_addr (wr_addr),
        .wr_data ({pixel.pixel_missing, pixel.pixel_value}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Division and result
    assign abs_sum = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    nwmf_divider #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (launch_reg),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign mean  = neg_reg ? -RES_W'(q_reg) : RES_W'(q_reg);
    assign v_ext = RES_W'(cen_v_reg);

    always_comb
    begin
        case (fm_reg)
            nwmf_pkg::MODE_SHARPEN: res_calc = v_ext + v_ext - mean;
            nwmf_pkg::MODE_EDGE:    res_calc = v_ext - mean;
            default:                res_calc = mean;
        endcase
    end

    assign is_last = (out_row_reg == hlast) && (out_col_reg == wlast);
    assign load    = (state_reg == S_OUT) && (!out_valid_reg || result.ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (emit) state_next = S_CTR;
            S_CTR:  state_next = S_SCAN;
            S_SCAN: if (scan_end) state_next = S_WAIT;
            S_WAIT: state_next = S_PREP;
            S_PREP: state_next = cen_missing_reg ? S_OUT : S_DIV;
            S_DIV:  if (div_done) state_next = S_OUT;
            S_OUT:  if (load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tag_reg    <= '0;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tag_reg    <= tag_next;
            launch_reg <= (state_reg == S_PREP) && !cen_missing_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            dx_reg        <= r_neg;
            dy_reg        <= r_neg;
            scan_slot_reg <= start_slot;
            sum_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (state_reg == S_SCAN)
            begin
                if (dx_reg == r_pos)
                begin
                    dx_reg        <= r_neg;
                    dy_reg        <= dy_reg + 1'b1;
                    scan_slot_reg <= (scan_slot_reg == SLOT_W'(RING - 1)) ?
                                     '0 : scan_slot_reg + 1'b1;
                end
                else
                begin
                    dx_reg <= dx_reg + 1'b1;
                end
            end
            if (tag_reg.valid && !tag_reg.centre && !rd_data[VAL_W])
            begin
                sum_reg <= sum_reg + SUM_W'($signed(rd_data[VAL_W-1:0]));
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
        if (tag_reg.valid && tag_reg.centre)
        begin
            cen_missing_reg <= rd_data[VAL_W];
            cen_v_reg       <= $signed(rd_data[VAL_W-1:0]);
        end
        if (state_reg == S_PREP)
        begin
            dvd_reg <= {abs_sum, 1'b0} + DIV_W'(cnt_reg);
            dvs_reg <= {cnt_reg, 1'b0};
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (div_done)
        begin
            q_reg <= div_q;
        end
    end

    // Position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            in_lin_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            out_lin_reg  <= '0;
        end
        else if (cfg_hit || (load && is_last))
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            in_lin_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            out_lin_reg  <= '0;
        end
        else if (load)
        begin
            out_lin_reg <= out_lin_reg + 1'b1;
            if (out_col_reg == wlast)
            begin
                out_col_reg  <= '0;
                out_row_reg  <= out_row_reg + 16'd1;
                out_slot_reg <= (out_slot_reg == SLOT_W'(RING - 1)) ?
                                '0 : out_slot_reg + 1'b1;
            end
            else
            begin
                out_col_reg <= out_col_reg + 1'b1;
            end
        end
        else if (has_cur)
        begin
            in_lin_reg <= in_lin_reg + 1'b1;
            if (in_col_reg == wlast)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= in_row_reg + 16'd1;
                in_slot_reg <= (in_slot_reg == SLOT_W'(RING - 1)) ?
                               '0 : in_slot_reg + 1'b1;
            end
            else
            begin
                in_col_reg <= in_col_reg + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_value_reg   <= cen_missing_reg ? '0 : res_calc;
            res_missing_reg <= cen_missing_reg;
            res_last_reg    <= is_last;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.result_value   = res_value_reg;
    assign result.result_missing = res_missing_reg;
    assign result.frame_last     = res_last_reg;

`ifndef SYNTHESIS
    a_tag_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        tag_reg.valid |-> ($past(state_reg) == S_CTR || $past(state_reg) == S_SCAN))
        else $error("read tag without a line-store read");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("quotient arrived outside division wait");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire
